// ===== hw/rtl/gs_pkg.sv =====
package gs_pkg;

   // fixed field widths
   localparam int SMP_W  = 16;               // Q8.8 sample
   localparam int Z_W    = 16;               // Q5.11 result
   localparam int SUM_W  = 22;               // signed sum of up to 64 samples
   localparam int SQ_W   = 31;               // square of one sample
   localparam int QS_W   = 37;               // sum of up to 64 squares
   localparam int NQ_W   = 44;               // n*Q and S*S
   localparam int D_W    = 43;               // n*Q - S*S, never negative
   localparam int FRAC_SH = 20;              // extra bits under the root
   localparam int V_W    = D_W + FRAC_SH;    // radicand
   localparam int RT_W   = 32;               // final root
   localparam int NUM_W  = 24;               // n*x - S, signed
   localparam int MAG_W  = NUM_W - 1;
   localparam int DVD_W  = MAG_W + 22;       // rounded dividend
   localparam int DVS_W  = RT_W + 1;         // 2*root
   localparam int CNT_W  = 6;                // iteration counter
   localparam int SQRT_STEPS = V_W / 2 + 1;  // radicand bit pairs
   localparam int DIV_STEPS  = DVD_W;

   localparam logic signed [Z_W-1:0] Z_MAX = 16'sh7FFF;
   localparam logic signed [Z_W-1:0] Z_MIN = -16'sh8000;

   // controller to datapath
   typedef struct packed {
      logic ld;          // store an accepted sample
      logic dev_mul;     // form n*Q and S*S
      logic sqrt_init;
      logic sqrt_step;
      logic rd_issue;    // read the store at the element index
      logic elem_mul;    // form n*x
      logic div_init;
      logic div_step;
      logic out_load;    // latch the result payload
      logic idx_inc;
      logic clear;       // end of group
   } gs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_zero;
      logic elem_last;
   } gs_sts_type;

endpackage

// ===== hw/rtl/gs_req_if.sv =====
interface gs_req_if;
   import gs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample;
   logic                    group_end;

   modport source (output valid, output sample, output group_end, input ready);
   modport sink   (input valid, input sample, input group_end, output ready);
endinterface

// ===== hw/rtl/gs_rsp_if.sv =====
interface gs_rsp_if;
   import gs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic signed [Z_W-1:0] zscore;
   logic                  final_res;
   logic                  dropped;

   modport source (output valid, output zscore, output final_res, output dropped,
                   input ready);
   modport sink   (input valid, input zscore, input final_res, input dropped,
                   output ready);
endinterface

// ===== hw/rtl/gs_ctrl.sv =====
module gs_ctrl
   import gs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_group_end,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  gs_sts_type sts,
   output gs_cmd_type cmd
);

   localparam logic [3:0] ST_LOAD = 4'd0;
   localparam logic [3:0] ST_DEV0 = 4'd1;
   localparam logic [3:0] ST_DEV1 = 4'd2;
   localparam logic [3:0] ST_DEV2 = 4'd3;
   localparam logic [3:0] ST_SQRT = 4'd4;
   localparam logic [3:0] ST_RD   = 4'd5;
   localparam logic [3:0] ST_MUL  = 4'd6;
   localparam logic [3:0] ST_DIVI = 4'd7;
   localparam logic [3:0] ST_DIV  = 4'd8;
   localparam logic [3:0] ST_FIN  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       req_xfer;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_xfer  = req_valid && req_ready;

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.ld = req_xfer;
            if (req_xfer && req_group_end) state_in = ST_DEV0;
         end
         ST_DEV0: state_in = ST_DEV1;
         ST_DEV1: begin
            cmd.dev_mul = 1'b1;
            state_in    = ST_DEV2;
         end
         ST_DEV2: begin
            cmd.sqrt_init = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.cnt_zero) state_in = ST_RD;
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.elem_mul = 1'b1;
            state_in     = ST_DIVI;
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.cnt_zero) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (sts.elem_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/gs_dpath.sv =====
module gs_dpath
   import gs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gs_cmd_type              cmd,
   output gs_sts_type              sts,
   input  logic signed [SMP_W-1:0] sample,
   output logic signed [Z_W-1:0]   zscore,
   output logic                    final_res,
   output logic                    dropped
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);

   // sample store
   logic signed [SMP_W-1:0] mem [MAX_LEN];
   logic signed [SMP_W-1:0] rd_ff;

   // group accumulators
   logic [CW-1:0]           fill_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [QS_W-1:0]         qs_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic                    sqv_ff;
   logic                    ovf_ff;
   logic                    full;

   // deviation and root
   logic [NQ_W-1:0] nq_ff, ss_ff;
   logic [NQ_W-1:0] dev_w;
   logic [V_W-1:0]  v_ff, bit_ff, root_ff;
   logic [V_W:0]    trial;

   // per element
   logic [AW-1:0]           idx_ff;
   logic signed [NUM_W-1:0] nx_ff;
   logic signed [NUM_W-1:0] num_w;
   logic [MAG_W-1:0]        mag_w;
   logic                    neg_ff, zero_ff;
   logic [DVD_W-1:0]        quo_ff;
   logic [DVS_W-1:0]        dvs_ff;
   logic [DVS_W-1:0]        rem_ff;
   logic [DVS_W:0]          rem_sh;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [Z_W-1:0]   z_w;

   assign full = (fill_ff == CW'(MAX_LEN));

   // load: store and running sum; squares are summed in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.ld && !full) begin
         mem[fill_ff[AW-1:0]] <= sample;
         sq_ff <= SQ_W'(32'(sample) * 32'(sample));
      end
      if (cmd.rd_issue) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fill_ff <= '0;
         sum_ff  <= '0;
         qs_ff   <= '0;
         sqv_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
         idx_ff  <= '0;
      end else begin
         sqv_ff <= cmd.ld && !full;
         if (sqv_ff) qs_ff <= qs_ff + QS_W'(sq_ff);
         if (cmd.ld) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
               sum_ff  <= sum_ff + SUM_W'(sample);
            end
         end
         if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
      end
   end

   // n*Q and S*S
   always_ff @(posedge clock) begin
      if (cmd.dev_mul) begin
         nq_ff <= NQ_W'(NQ_W'(fill_ff) * NQ_W'(qs_ff));
         ss_ff <= NQ_W'($signed(NQ_W'(sum_ff)) * $signed(NQ_W'(sum_ff)));
      end
   end

   assign dev_w = nq_ff - ss_ff;
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // bit-pair square root, one pair per cycle
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         v_ff    <= {dev_w[D_W-1:0], {FRAC_SH{1'b0}}};
         root_ff <= '0;
         bit_ff  <= {1'b1, {(V_W-1){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if ({1'b0, v_ff} >= trial) begin
            v_ff    <= V_W'({1'b0, v_ff} - trial);
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // n*x for the element being read
   always_ff @(posedge clock) begin
      if (cmd.elem_mul) nx_ff <= NUM_W'(NUM_W'($signed({1'b0, fill_ff})) * NUM_W'(rd_ff));
   end

   assign num_w  = nx_ff - NUM_W'(sum_ff);
   assign mag_w  = num_w[NUM_W-1] ? MAG_W'(-num_w) : MAG_W'(num_w);
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quo_ff  <= {mag_w, 22'b0} + DVD_W'(root_ff[RT_W-1:0]);
         dvs_ff  <= {root_ff[RT_W-1:0], 1'b0};
         rem_ff  <= '0;
         neg_ff  <= num_w[NUM_W-1];
         zero_ff <= (root_ff == '0) || (num_w == '0);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_ff <= DVS_W'(rem_sh - {1'b0, dvs_ff});
            quo_ff <= {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= DVS_W'(rem_sh);
            quo_ff <= {quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   // shared iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.sqrt_init) begin
         cnt_ff <= CNT_W'(SQRT_STEPS - 1);
      end else if (cmd.div_init) begin
         cnt_ff <= CNT_W'(DIV_STEPS - 1);
      end else if ((cmd.sqrt_step || cmd.div_step) && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // sign and saturation
   always_comb begin
      if (zero_ff) begin
         z_w = '0;
      end else if (neg_ff) begin
         if (quo_ff > DVD_W'(32768)) z_w = Z_MIN;
         else                        z_w = -$signed(Z_W'(quo_ff));
      end else begin
         if (quo_ff > DVD_W'(32767)) z_w = Z_MAX;
         else                        z_w = $signed(Z_W'(quo_ff));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         zscore    <= z_w;
         final_res <= (CW'(idx_ff) + 1'b1 == fill_ff);
         dropped   <= ovf_ff;
      end
   end

   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.elem_last = (CW'(idx_ff) + 1'b1 == fill_ff);

endmodule

// ===== hw/rtl/group_standardizer.sv =====
// Z-score standardizer: signed Q8.8 samples are taken one per cycle until the
// sample marked group_end; up to MAX_LEN are stored, later ones are dropped and
// every result of that group carries the dropped flag. The group then forms
// n*Q - S*S and takes the bit-pair square root. Each stored sample then takes a
// store read, a multiply, a divider setup, a restoring divide, a result load
// and a transfer on the output, which the receiver may stall. Results are
// (x - mean) / stdev in saturated Q5.11 and leave in sample order, the last one
// marked final_res; no new sample is taken until the last result is transferred.
module group_standardizer
   import gs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input logic      clock,
   input logic      reset,
   gs_req_if.sink   req_ch,
   gs_rsp_if.source rsp_ch
);

   gs_cmd_type cmd;
   gs_sts_type sts;

   // sequencer
   gs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_group_end (req_ch.group_end),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // arithmetic and store
   gs_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .sample    (req_ch.sample),
      .zscore    (rsp_ch.zscore),
      .final_res (rsp_ch.final_res),
      .dropped   (rsp_ch.dropped)
   );

   // no sample is taken while a result is offered
   a_no_load_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("sample taken while a result is pending");

   // group end stops the loading
   a_end_stops_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.group_end |=> !req_ch.ready)
      else $error("loading continued after group end");

   // the final transfer reopens the input
   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.final_res |=> req_ch.ready && !rsp_ch.valid)
      else $error("input not reopened after final result");

endmodule

// ===== verif/tb_group_standardizer.sv =====
module tb_group_standardizer;
   timeunit 1ns;
   timeprecision 1ps;
   import gs_pkg::*;

   localparam int GROUP_MAX = 64;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    group_end;
   } sample_item_type;

   typedef struct packed {
      logic signed [Z_W-1:0] zscore;
      logic                  final_res;
      logic                  dropped;
   } zscore_item_type;

   // directed stimulus row: a transfer and, where obvious, its result
   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    group_end;
      logic                    has_known;
      logic signed [Z_W-1:0]   known_z;
   } directed_row_type;

   logic clock;
   logic reset;
   int   error_count;

   gs_req_if req_ch ();
   gs_rsp_if rsp_ch ();

   group_standardizer #(.MAX_LEN(GROUP_MAX)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // predictor state
   logic signed [SMP_W-1:0] group_store [GROUP_MAX];
   bit                      group_known [GROUP_MAX];
   logic signed [Z_W-1:0]   group_kz [GROUP_MAX];
   int unsigned             group_fill;
   longint                  group_sum;
   bit                      group_lost;

   zscore_item_type zscore_queue [$];
   logic signed [Z_W-1:0] known_queue [$];
   bit                    known_flag [$];

   sample_item_type sample_queue [$];
   bit           sample_known [$];
   logic signed [Z_W-1:0] sample_known_z [$];

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // time limit
   initial begin
      #300ms;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // fold one sample into the group; on group end queue its zscores
   task automatic predict_zscores(input sample_item_type it, input bit kn,
                                  input logic signed [Z_W-1:0] kz);
      longint          sq;
      longint          dev;
      longint          num;
      longint unsigned root;
      longint unsigned mag;
      longint unsigned q;
      longint          z;
      zscore_item_type r;
      sq = 0;
      if (group_fill < GROUP_MAX) begin
         group_store[group_fill] = it.sample;
         group_known[group_fill] = kn;
         group_kz[group_fill] = kz;
         group_fill++;
         group_sum += it.sample;
      end else begin
         group_lost = 1'b1;
      end
      if (it.group_end) begin
         for (int i = 0; i < group_fill; i++)
            sq += longint'(group_store[i]) * longint'(group_store[i]);
         dev = longint'(group_fill) * sq - group_sum * group_sum;
         root = 0;
         if (dev > 0) root = int_sqrt(longint'(dev) << 20);
         for (int i = 0; i < group_fill; i++) begin
            num = longint'(group_fill) * longint'(group_store[i]) - group_sum;
            z = 0;
            if (root != 0 && num != 0) begin
               mag = longint'(num < 0 ? -num : num) << 21;
               q = (2 * mag + root) / (2 * root);
               if (num > 0) z = (q > 32767) ? 32767 : longint'(q);
               else z = (q > 32768) ? -32768 : -longint'(q);
            end
            r.zscore = z[Z_W-1:0];
            r.final_res = (i + 1 == group_fill);
            r.dropped = group_lost;
            zscore_queue.push_back(r);
            known_flag.push_back(group_known[i]);
            known_queue.push_back(group_kz[i]);
         end
         group_fill = 0;
         group_sum = 0;
         group_lost = 1'b0;
      end
   endtask

   // directed table: extremes, zero deviation and short groups
   localparam int DIR_N = 14;
   directed_row_type directed_rows [DIR_N] = '{
      '{16'sh0100, 1'b0, 1'b1, 16'sh0000},
      '{16'sh0100, 1'b1, 1'b1, 16'sh0000},
      '{-16'sh8000, 1'b0, 1'b1, -16'sh0800},
      '{16'sh7FFF, 1'b1, 1'b1, 16'sh0800},
      '{-16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{-16'sh8000, 1'b1, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
      '{16'sh0001, 1'b0, 1'b0, 16'sh0000},
      '{-16'sh0001, 1'b1, 1'b0, 16'sh0000},
      '{16'sh5555, 1'b0, 1'b0, 16'sh0000},
      '{-16'sh2AAB, 1'b1, 1'b0, 16'sh0000}
   };

   task automatic push_sample(input logic signed [SMP_W-1:0] s, input bit e,
                              input bit kn, input logic signed [Z_W-1:0] kz);
      sample_item_type it;
      it.sample = s;
      it.group_end = e;
      sample_queue.push_back(it);
      sample_known.push_back(kn);
      sample_known_z.push_back(kz);
   endtask

   // build the stimulus list
   initial begin
      int len;
      int mode;
      logic signed [SMP_W-1:0] s;
      foreach (directed_rows[k])
         push_sample(directed_rows[k].sample, directed_rows[k].group_end,
                     directed_rows[k].has_known, directed_rows[k].known_z);
      // full store then overflow samples
      for (int k = 0; k < 66; k++)
         push_sample(16'($urandom), k == 65, 1'b0, '0);
      while (sample_queue.size() < 310) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
         if (sample_queue.size() + len > 310) len = 310 - sample_queue.size();
         mode = $urandom_range(0, 3);
         for (int k = 0; k < len; k++) begin
            case (mode)
               0: s = 16'($urandom);
               1: s = $signed(16'($urandom_range(0, 15))) - 16'sd8;
               2: s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
               default: s = 16'($urandom_range(0, 1) != 0 ? 16'h0300 : 16'h0301);
            endcase
            push_sample(s, k == len - 1, 1'b0, '0);
         end
      end
   end

   // sender: one transfer per item with a random gap
   initial begin
      int gap;
      sample_item_type it;
      error_count = 0;
      group_fill = 0;
      group_sum = 0;
      group_lost = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.group_end = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (sample_queue.size() != 0) begin
         it = sample_queue.pop_front();
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.sample <= it.sample;
         req_ch.group_end <= it.group_end;
         do @(posedge clock); while (!req_ch.ready);
         predict_zscores(it, sample_known.pop_front(), sample_known_z.pop_front());
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;
      while (zscore_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // receiver: random stalls and result checks
   initial begin
      int stall;
      zscore_item_type want;
      bit kn;
      logic signed [Z_W-1:0] kz;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
         if (zscore_queue.size() == 0) begin
            report_mismatch("unexpected zscore", rsp_ch.zscore, 0);
         end else begin
            want = zscore_queue.pop_front();
            kn = known_flag.pop_front();
            kz = known_queue.pop_front();
            if (kn && kz != want.zscore)
               report_mismatch("predictor vs table", want.zscore, kz);
            if (rsp_ch.zscore !== want.zscore)
               report_mismatch("zscore", rsp_ch.zscore, want.zscore);
            if (rsp_ch.final_res !== want.final_res)
               report_mismatch("final_res", rsp_ch.final_res, want.final_res);
            if (rsp_ch.dropped !== want.dropped)
               report_mismatch("dropped", rsp_ch.dropped, want.dropped);
         end
         @(negedge clock);
      end
   end

endmodule
